// ----- src/srra_pkg.sv -----
package srra_pkg;

   // Address space of both frames wraps at 2^20 pixels
   localparam int ADDR_W = 20;

   // Register field widths
   localparam int MODE_W  = 2;
   localparam int SIZE_W  = 11;
   localparam int PIVOT_W = 10;

   // Register port geometry: eight 32-bit registers on a word grid
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_ROTATION_MODE  = 3'd0,
      REG_SEGMENT_WIDTH  = 3'd1,
      REG_SEGMENT_HEIGHT = 3'd2,
      REG_SOURCE_PITCH   = 3'd3,
      REG_SOURCE_BASE    = 3'd4,
      REG_TARGET_PITCH   = 3'd5,
      REG_TARGET_PIVOT_X = 3'd6,
      REG_TARGET_PIVOT_Y = 3'd7
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      ROT_NONE = 2'd0,
      ROT_90   = 2'd1,
      ROT_180  = 2'd2,
      ROT_270  = 2'd3
   } rot_mode_type;

endpackage

// ----- src/segment_rotate_remap_address.sv -----
// Segment rotate and remap address generator. Pixels of a rectangular segment
// enter on the req_ stream in raster order (column fastest), one item each.
// For every pixel the block returns on the rsp_ stream the linear source
// address (source_base + column + row * source_pitch), the linear target
// address after rotating the segment by 0, 90, 180 or 270 degrees
// counterclockwise and shifting it to the target pivot, and the pixel itself;
// rsp_tlast marks the final pixel of the segment, after which the column and
// row counters restart at the origin. All addresses wrap modulo 2^20. A
// segment size of 0 acts as 1 and a size above MAX_DIM acts as MAX_DIM. The
// block takes one item per clock for as long as the result side keeps
// taking results; a result passes through two register stages (products of
// the row terms, then the final sums) before it is offered. req_tready
// follows rsp_tready combinationally when both stages are full.
// Registers (word addresses): 0x00 rotation_mode, 0x04 segment_width,
// 0x08 segment_height, 0x0C source_pitch, 0x10 source_base, 0x14
// target_pitch, 0x18 target_pivot_x, 0x1C target_pivot_y. Write them only
// while no item is in flight.
module segment_rotate_remap_address #(
   parameter int MAX_DIM    = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // pixel items in
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((PIXEL_BITS+7)/8)*8-1:0]    req_tdata,   // pixel_value
   // address items out
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // source_address [19:0], target_address [39:20], pixel_out above
   output logic [((2*srra_pkg::ADDR_W+PIXEL_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                               rsp_tlast,   // last_pixel
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [srra_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [srra_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [srra_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import srra_pkg::*;

   localparam int CNT_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CMP_W    = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
   localparam int OUT_W    = ((2 * ADDR_W + PIXEL_BITS + 7) / 8) * 8;
   localparam int OUT_PAD  = OUT_W - 2 * ADDR_W - PIXEL_BITS;
   localparam int DIM_TOP  = (MAX_DIM > (1 << SIZE_W) - 1) ? (1 << SIZE_W) - 1 : MAX_DIM;
   localparam logic [SIZE_W-1:0] DIM_CLAMP = SIZE_W'(DIM_TOP);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   logic [MODE_W-1:0]  rotation_mode_ff;
   logic [SIZE_W-1:0]  segment_width_ff;
   logic [SIZE_W-1:0]  segment_height_ff;
   logic [SIZE_W-1:0]  source_pitch_ff;
   logic [ADDR_W-1:0]  source_base_ff;
   logic [SIZE_W-1:0]  target_pitch_ff;
   logic [PIVOT_W-1:0] target_pivot_x_ff;
   logic [PIVOT_W-1:0] target_pivot_y_ff;

   logic          csr_write;
   csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_mode_ff  <= MODE_W'(ROT_NONE);
         segment_width_ff  <= SIZE_W'(1);
         segment_height_ff <= SIZE_W'(1);
         source_pitch_ff   <= SIZE_W'(1);
         source_base_ff    <= '0;
         target_pitch_ff   <= SIZE_W'(1);
         target_pivot_x_ff <= '0;
         target_pivot_y_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_ROTATION_MODE:  rotation_mode_ff  <= csr_pwdata[MODE_W-1:0];
            REG_SEGMENT_WIDTH:  segment_width_ff  <= csr_pwdata[SIZE_W-1:0];
            REG_SEGMENT_HEIGHT: segment_height_ff <= csr_pwdata[SIZE_W-1:0];
            REG_SOURCE_PITCH:   source_pitch_ff   <= csr_pwdata[SIZE_W-1:0];
            REG_SOURCE_BASE:    source_base_ff    <= csr_pwdata[ADDR_W-1:0];
            REG_TARGET_PITCH:   target_pitch_ff   <= csr_pwdata[SIZE_W-1:0];
            REG_TARGET_PIVOT_X: target_pivot_x_ff <= csr_pwdata[PIVOT_W-1:0];
            REG_TARGET_PIVOT_Y: target_pivot_y_ff <= csr_pwdata[PIVOT_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      case (csr_index)
         REG_ROTATION_MODE:  csr_prdata = CSR_DATA_W'(rotation_mode_ff);
         REG_SEGMENT_WIDTH:  csr_prdata = CSR_DATA_W'(segment_width_ff);
         REG_SEGMENT_HEIGHT: csr_prdata = CSR_DATA_W'(segment_height_ff);
         REG_SOURCE_PITCH:   csr_prdata = CSR_DATA_W'(source_pitch_ff);
         REG_SOURCE_BASE:    csr_prdata = CSR_DATA_W'(source_base_ff);
         REG_TARGET_PITCH:   csr_prdata = CSR_DATA_W'(target_pitch_ff);
         REG_TARGET_PIVOT_X: csr_prdata = CSR_DATA_W'(target_pivot_x_ff);
         REG_TARGET_PIVOT_Y: csr_prdata = CSR_DATA_W'(target_pivot_y_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Effective segment size: zero acts as one, oversize clamps to MAX_DIM
   // ---------------------------------------------------------------------
   logic [SIZE_W-1:0] eff_width;
   logic [SIZE_W-1:0] eff_height;
   logic [SIZE_W-1:0] width_last;
   logic [SIZE_W-1:0] height_last;

   always_comb begin
      if (segment_width_ff == '0)
         eff_width = SIZE_W'(1);
      else if (segment_width_ff > DIM_CLAMP)
         eff_width = DIM_CLAMP;
      else
         eff_width = segment_width_ff;

      if (segment_height_ff == '0)
         eff_height = SIZE_W'(1);
      else if (segment_height_ff > DIM_CLAMP)
         eff_height = DIM_CLAMP;
      else
         eff_height = segment_height_ff;
   end

   assign width_last  = eff_width - SIZE_W'(1);
   assign height_last = eff_height - SIZE_W'(1);

   // ---------------------------------------------------------------------
   // Handshake: the whole chain advances wherever the next place is free
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_advance;
   logic s1_load;
   logic req_accept;

   assign out_advance = ~rsp_valid_ff | rsp_tready;
   assign s1_load     = ~s1_valid_ff | out_advance;
   assign req_tready  = s1_load;
   assign req_accept  = req_tvalid & req_tready;

   assign s1_valid_in  = req_accept | (s1_valid_ff & ~out_advance);
   assign rsp_valid_in = out_advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Segment counters: advance once per accepted item
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0] column_count_ff, column_count_in;
   logic [CNT_W-1:0] row_count_ff, row_count_in;
   logic             col_end;
   logic             row_end;

   assign col_end = CMP_W'(column_count_ff) >= CMP_W'(width_last);
   assign row_end = CMP_W'(row_count_ff) >= CMP_W'(height_last);

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (req_accept) begin
         if (col_end) begin
            column_count_in = '0;
            row_count_in    = row_end ? '0 : row_count_ff + CNT_W'(1);
         end else begin
            column_count_in = column_count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: rotate the local coordinates, add the pivot, form row products
   // ---------------------------------------------------------------------
   logic [ADDR_W-1:0] dx_wide;
   logic [ADDR_W-1:0] dy_wide;
   logic [ADDR_W-1:0] x_rot;
   logic [ADDR_W-1:0] y_rot;
   logic [ADDR_W-1:0] x_tgt;
   logic [ADDR_W-1:0] y_tgt;

   assign dx_wide = ADDR_W'(column_count_ff);
   assign dy_wide = ADDR_W'(row_count_ff);

   // Differences wrap when a counter runs past a size lowered mid segment
   always_comb begin
      case (rot_mode_type'(rotation_mode_ff))
         ROT_NONE: begin
            x_rot = dx_wide;
            y_rot = dy_wide;
         end
         ROT_90: begin
            x_rot = dy_wide;
            y_rot = ADDR_W'(width_last) - dx_wide;
         end
         ROT_180: begin
            x_rot = ADDR_W'(width_last) - dx_wide;
            y_rot = ADDR_W'(height_last) - dy_wide;
         end
         ROT_270: begin
            x_rot = ADDR_W'(height_last) - dy_wide;
            y_rot = dx_wide;
         end
         default: begin
            x_rot = dx_wide;
            y_rot = dy_wide;
         end
      endcase
   end

   assign x_tgt = x_rot + ADDR_W'(target_pivot_x_ff);
   assign y_tgt = y_rot + ADDR_W'(target_pivot_y_ff);

   logic [ADDR_W-1:0]     s1_dx_ff;
   logic [ADDR_W-1:0]     s1_src_row_ff;
   logic [ADDR_W-1:0]     s1_x_tgt_ff;
   logic [ADDR_W-1:0]     s1_tgt_row_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic                  s1_last_ff;

   // Payload needs no reset; hold while stalled
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_dx_ff      <= dx_wide;
         s1_src_row_ff <= dy_wide * ADDR_W'(source_pitch_ff);
         s1_x_tgt_ff   <= x_tgt;
         s1_tgt_row_ff <= y_tgt * ADDR_W'(target_pitch_ff);
         s1_pixel_ff   <= req_tdata[PIXEL_BITS-1:0];
         s1_last_ff    <= col_end & row_end;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: final sums into the result register
   // ---------------------------------------------------------------------
   logic [ADDR_W-1:0]     rsp_src_ff;
   logic [ADDR_W-1:0]     rsp_tgt_ff;
   logic [PIXEL_BITS-1:0] rsp_pixel_ff;
   logic                  rsp_last_ff;

   always_ff @(posedge clock) begin
      if (out_advance && s1_valid_ff) begin
         rsp_src_ff   <= source_base_ff + s1_dx_ff + s1_src_row_ff;
         rsp_tgt_ff   <= s1_x_tgt_ff + s1_tgt_row_ff;
         rsp_pixel_ff <= s1_pixel_ff;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

   generate
      if (OUT_PAD > 0) begin : g_out_pad
         assign rsp_tdata = {{OUT_PAD{1'b0}}, rsp_pixel_ff, rsp_tgt_ff, rsp_src_ff};
      end else begin : g_out_nopad
         assign rsp_tdata = {rsp_pixel_ff, rsp_tgt_ff, rsp_src_ff};
      end
   endgenerate

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   a_stall_keeps_s1: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_advance) |=> s1_valid_ff)
      else $error("stage 1 item dropped while the result register was stalled");

   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result raised without an item in stage 1");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && col_end && row_end) |=>
         (column_count_ff == '0 && row_count_ff == '0))
      else $error("counters did not restart after the last pixel");

   a_column_step: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !col_end) |=>
         (column_count_ff == $past(column_count_ff) + CNT_W'(1) &&
          row_count_ff == $past(row_count_ff)))
      else $error("column counter did not advance by one");

   a_idle_counters: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> ($stable(column_count_ff) && $stable(row_count_ff)))
      else $error("counters moved without an accepted item");

endmodule

// ----- tb/segment_rotate_remap_address_tb.sv -----
`timescale 1ns / 1ps

module segment_rotate_remap_address_tb;
   import srra_pkg::*;

   localparam int MAX_DIM     = 1024;
   localparam int PIXEL_BITS  = 16;
   localparam int REQ_W       = ((PIXEL_BITS + 7) / 8) * 8;
   localparam int RSP_W       = ((2 * ADDR_W + PIXEL_BITS + 7) / 8) * 8;
   localparam int LATENCY     = 2;
   localparam int PERIOD      = 4;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int ITEM_TARGET = 1800;
   localparam int HOLD_CYCLES = 300;
   localparam logic [31:0] ADDR_MASK = 32'h000F_FFFF;

   // One expected result item: the two addresses, the pixel and the last flag
   typedef struct {
      logic [ADDR_W-1:0]     source_address;
      logic [ADDR_W-1:0]     target_address;
      logic [PIXEL_BITS-1:0] pixel;
      logic                  last_pixel;
   } remap_result_type;

   // Mirrors the register file and the segment counters, works out the remap of every
   // accepted pixel and holds the results still to come out of the block.
   class remap_scoreboard;
      rot_mode_type          rotation;
      logic [SIZE_W-1:0]     seg_width, seg_height, src_pitch, tgt_pitch;
      logic [ADDR_W-1:0]     src_base;
      logic [PIVOT_W-1:0]    pivot_x, pivot_y;
      logic [9:0]            column, row;
      remap_result_type      awaited_remaps[$];
      int                    mismatches;

      function new();
         rotation   = ROT_NONE;
         seg_width  = 1;
         seg_height = 1;
         src_pitch  = 1;
         tgt_pitch  = 1;
         src_base   = '0;
         pivot_x    = '0;
         pivot_y    = '0;
         column     = '0;
         row        = '0;
         mismatches = 0;
      endfunction

      function int pending();
         return awaited_remaps.size();
      endfunction

      // zero acts as one, anything above the maximum as the maximum
      function logic [31:0] clamp_size(logic [SIZE_W-1:0] s);
         if (s == 0) return 32'd1;
         if (s > MAX_DIM) return 32'(MAX_DIM);
         return 32'(s);
      endfunction

      function void write_register(csr_index_type idx, logic [31:0] value);
         case (idx)
            REG_ROTATION_MODE:  rotation   = rot_mode_type'(value[MODE_W-1:0]);
            REG_SEGMENT_WIDTH:  seg_width  = value[SIZE_W-1:0];
            REG_SEGMENT_HEIGHT: seg_height = value[SIZE_W-1:0];
            REG_SOURCE_PITCH:   src_pitch  = value[SIZE_W-1:0];
            REG_SOURCE_BASE:    src_base   = value[ADDR_W-1:0];
            REG_TARGET_PITCH:   tgt_pitch  = value[SIZE_W-1:0];
            REG_TARGET_PIVOT_X: pivot_x    = value[PIVOT_W-1:0];
            REG_TARGET_PIVOT_Y: pivot_y    = value[PIVOT_W-1:0];
            default: ;
         endcase
      endfunction

      function void predict_remap(logic [PIXEL_BITS-1:0] pixel);
         logic [31:0]      w, h, dx, dy, xt, yt, src, tgt;
         logic             col_end, row_end;
         remap_result_type r;
         w  = clamp_size(seg_width);
         h  = clamp_size(seg_height);
         dx = 32'(column);
         dy = 32'(row);
         src = 32'(src_base) + dx + dy * 32'(src_pitch);
         case (rotation)
            ROT_90:  begin xt = dy;            yt = w - 32'd1 - dx; end
            ROT_180: begin xt = w - 32'd1 - dx; yt = h - 32'd1 - dy; end
            ROT_270: begin xt = h - 32'd1 - dy; yt = dx;            end
            default: begin xt = dx;            yt = dy;            end
         endcase
         xt  = (xt + 32'(pivot_x)) & ADDR_MASK;
         yt  = (yt + 32'(pivot_y)) & ADDR_MASK;
         tgt = xt + yt * 32'(tgt_pitch);
         // a counter at or past its last index closes the row or the segment
         col_end = (dx >= w - 32'd1);
         row_end = (dy >= h - 32'd1);
         r.source_address = src[ADDR_W-1:0];
         r.target_address = tgt[ADDR_W-1:0];
         r.pixel          = pixel;
         r.last_pixel     = col_end && row_end;
         awaited_remaps.push_back(r);
         if (col_end) begin
            column = '0;
            row    = row_end ? 10'd0 : row + 10'd1;
         end else begin
            column = column + 10'd1;
         end
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         $display("%0t ERROR %s: got %0h, want %0h", $time, what, got, want);
      endtask

      task check_remap(input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] tgt,
                       input logic [PIXEL_BITS-1:0] pixel, input logic last);
         remap_result_type want;
         if (awaited_remaps.size() == 0) begin
            report_mismatch("result item with none awaited", 32'(src), 32'(0));
            return;
         end
         want = awaited_remaps.pop_front();
         if (src !== want.source_address)
            report_mismatch("source_address", 32'(src), 32'(want.source_address));
         if (tgt !== want.target_address)
            report_mismatch("target_address", 32'(tgt), 32'(want.target_address));
         if (pixel !== want.pixel)
            report_mismatch("pixel_out", 32'(pixel), 32'(want.pixel));
         if (last !== want.last_pixel)
            report_mismatch("last_pixel", 32'(last), 32'(want.last_pixel));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;    // pixel_value
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // source_address [19:0], target_address [39:20], pixel_out [55:40]
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;    // last_pixel
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   remap_scoreboard board = new();

   // Shared between the stimulus and the receiver: a steady phase has no idling on
   // either side, and a non-zero hold keeps the result side stalled until it counts down.
   bit steady = 1'b0;
   int hold_left = 0;
   int cycles = 0;

   segment_rotate_remap_address #(
      .MAX_DIM    (MAX_DIM),
      .PIXEL_BITS (PIXEL_BITS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Abandon the run if it hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Sample both streams at the rising edge. Check the result side first: the
   // pipeline is two deep, so a result never belongs to the item taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_remap(rsp_tdata[ADDR_W-1:0], rsp_tdata[2*ADDR_W-1:ADDR_W],
                              rsp_tdata[2*ADDR_W+PIXEL_BITS-1:2*ADDR_W], rsp_tlast);
         if (req_tvalid && req_tready)
            board.predict_remap(req_tdata[PIXEL_BITS-1:0]);
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 8);
      if (r < 70) return 0;
      if (r < 85) return $urandom_range(9, 64);
      if (r < 93) return MAX_DIM;
      return $urandom_range(MAX_DIM + 1, 2047);
   endfunction

   function automatic logic [31:0] pick_pitch();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 0;
      if (r < 30) return 2047;
      if (r < 40) return MAX_DIM;
      return $urandom_range(1, 2047);
   endfunction

   // Receiver: stall at random outside steady phases, and honour a long hold when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         int stall_left;
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = steady ? 0 : pick_gap();
         end
      end
   end

   // Called at a falling edge; drop the select at the falling edge after the write lands,
   // then return with the bus idle so that back-to-back writes never share a step.
   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.write_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one pixel after an optional gap; return at the falling edge after acceptance
   task automatic send_pixel(input logic [PIXEL_BITS-1:0] pixel);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(pixel);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drop valid and drain: every item gives a result, so an empty store means idle,
   // then allow the pipeline depth again before anything touches the registers.
   task automatic finish_burst();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   // A one-by-one segment closes on its first pixel, so the counters sit at the origin after
   task automatic restart_segment();
      write_csr(REG_SEGMENT_WIDTH, 1);
      write_csr(REG_SEGMENT_HEIGHT, 1);
      send_pixel($urandom_range(0, 65535));
      finish_burst();
   endtask

   // Rewrite a random subset of the rotation and addressing registers
   task automatic scramble_addressing();
      if ($urandom_range(0, 1)) write_csr(REG_ROTATION_MODE, $urandom_range(0, 3));
      if ($urandom_range(0, 1)) write_csr(REG_SOURCE_PITCH, pick_pitch());
      if ($urandom_range(0, 1)) write_csr(REG_TARGET_PITCH, pick_pitch());
      if ($urandom_range(0, 1))
         write_csr(REG_SOURCE_BASE, $urandom_range(0, 7) == 0 ? ADDR_MASK : $urandom & ADDR_MASK);
      if ($urandom_range(0, 1))
         write_csr(REG_TARGET_PIVOT_X, $urandom_range(0, 7) == 0 ? 1023 : $urandom_range(0, 1023));
      if ($urandom_range(0, 1))
         write_csr(REG_TARGET_PIVOT_Y, $urandom_range(0, 7) == 0 ? 1023 : $urandom_range(0, 1023));
   endtask

   initial begin
      rot_mode_type rm;
      int           sent;
      int           phase;
      int           count;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      sent        = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values give one-pixel segments: every item is last; pixel extremes
      send_pixel(16'h0000);
      send_pixel(16'hFFFF);
      finish_burst();

      // Two-by-two segment at the far end of the address space, each rotation in turn;
      // zero pitches on the last one so the row term vanishes
      write_csr(REG_SEGMENT_WIDTH, 2);
      write_csr(REG_SEGMENT_HEIGHT, 2);
      write_csr(REG_SOURCE_BASE, ADDR_MASK);
      write_csr(REG_TARGET_PIVOT_X, 1023);
      write_csr(REG_TARGET_PIVOT_Y, 1023);
      rm = rm.first();
      do begin
         write_csr(REG_ROTATION_MODE, 32'(rm));
         write_csr(REG_SOURCE_PITCH, rm == ROT_270 ? 0 : 2047);
         write_csr(REG_TARGET_PITCH, rm == ROT_270 ? 0 : 2047);
         repeat (4) send_pixel($urandom_range(0, 65535));
         finish_burst();
         rm = rm.next();
      end while (rm != rm.first());

      // Zero width acts as one column
      write_csr(REG_SEGMENT_WIDTH, 0);
      write_csr(REG_SEGMENT_HEIGHT, 3);
      repeat (3) send_pixel($urandom_range(0, 65535));
      finish_burst();

      // Narrow the segment while the column counter is past the new last column
      write_csr(REG_SEGMENT_WIDTH, 4);
      write_csr(REG_SEGMENT_HEIGHT, 2);
      repeat (3) send_pixel($urandom_range(0, 65535));
      finish_burst();
      write_csr(REG_SEGMENT_WIDTH, 2);
      repeat (2) send_pixel($urandom_range(0, 65535));
      finish_burst();

      // Random phases: new settings between bursts, counters carry across them
      for (phase = 0; sent < ITEM_TARGET; phase++) begin
         steady = ($urandom_range(0, 3) == 0);
         if (phase == 1) begin
            // Hold the result side off while the sender keeps offering: the block fills
            // and has to stall its input
            steady    = 1'b1;
            hold_left = HOLD_CYCLES;
            count     = 60;
         end else if (phase == 3 || phase == 6) begin
            // One full segment at the largest size along one axis, written oversize
            // so that it clamps; start it from the origin
            restart_segment();
            scramble_addressing();
            write_csr(REG_SEGMENT_WIDTH, phase == 3 ? 2047 : 1);
            write_csr(REG_SEGMENT_HEIGHT, phase == 3 ? 1 : 2047);
            count = MAX_DIM + $urandom_range(0, 3);
         end else begin
            scramble_addressing();
            if ($urandom_range(0, 2) != 0) write_csr(REG_SEGMENT_WIDTH, pick_size());
            if ($urandom_range(0, 2) != 0) write_csr(REG_SEGMENT_HEIGHT, pick_size());
            count = $urandom_range(1, 48);
         end
         repeat (count) send_pixel($urandom_range(0, 65535));
         sent += count;
         finish_burst();
      end

      steady = 1'b0;
      repeat (4 * LATENCY) @(negedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
